// ===== sv/asn1_string_charset_check_core_macros.svh =====
// Assertion macros shared by the string character-set checker.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASN1_STRING_CHARSET_CHECK_CORE_MACROS_SVH
`define ASN1_STRING_CHARSET_CHECK_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASN1CC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASN1CC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/asn1cc_pkg.sv =====
// Types, tag numbers, reason codes and character tables for the string checker.
// Depends on nothing; imported by every module of the block.
package asn1cc_pkg;

   localparam logic [4:0] TAG_UTF8      = 5'd12;
   localparam logic [4:0] TAG_PRINTABLE = 5'd19;
   localparam logic [4:0] TAG_T61       = 5'd20;
   localparam logic [4:0] TAG_IA5       = 5'd22;
   localparam logic [4:0] TAG_VISIBLE   = 5'd26;

   typedef enum logic [2:0] {
      RSN_OK    = 3'd0,
      RSN_CLASS = 3'd1,
      RSN_CHAR  = 3'd2,
      RSN_LEAD  = 3'd3,
      RSN_CONT  = 3'd4,
      RSN_TRUNC = 3'd5
   } rsn_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [4:0] string_tag;
      logic       is_universal;
      logic       first_byte;
      logic       last_byte;
      logic       empty_string;
   } item_type;

   typedef struct packed {
      logic       in_sequence;
      logic [1:0] continuation_left;
      rsn_type    error_latched;
   } state_type;

   typedef struct packed {
      logic    produce;
      rsn_type reason;
   } result_type;

   localparam state_type STATE_CLEAR = '{1'b0, 2'd0, RSN_OK};

   function automatic logic tag_supported(input logic univ, input logic [4:0] tag);
      return univ && (tag == TAG_UTF8 || tag == TAG_PRINTABLE || tag == TAG_T61 ||
                      tag == TAG_IA5 || tag == TAG_VISIBLE);
   endfunction

   function automatic rsn_type printable_check(input logic [7:0] b);
      rsn_type r;
      if (b == 8'h20) begin
         r = RSN_OK;
      end else if (b < 8'h27 || b > 8'h7a) begin
         r = RSN_CHAR;
      end else if (b == 8'h2a || b == 8'h3b || b == 8'h3c || b == 8'h3e || b == 8'h40) begin
         r = RSN_CHAR;
      end else begin
         r = RSN_OK;
      end
      return r;
   endfunction

endpackage

// ===== sv/asn1cc_check.sv =====
// Per-byte check: applies the string type's rules to one registered word and
// works out the next running state and the result. Uses asn1cc_pkg.
module asn1cc_check
   import asn1cc_pkg::*;
(
   input  item_type   item,
   input  state_type  cur,
   output state_type  nxt,
   output result_type res
);

   state_type base;
   state_type upd;
   rsn_type   r;
   logic      supported;
   logic [7:0] b;

   always_comb begin
      b         = item.data_byte;
      supported = tag_supported(item.is_universal, item.string_tag);
      base      = item.first_byte ? STATE_CLEAR : cur;
      upd       = base;
      r         = base.error_latched;
      if (base.error_latched == RSN_OK) begin
         if (!supported) begin
            r = RSN_CLASS;
         end else if (item.string_tag == TAG_PRINTABLE) begin
            r = printable_check(b);
         end else if (item.string_tag == TAG_UTF8) begin
            if (!base.in_sequence) begin
               if (!b[7]) begin
                  r = RSN_OK;
               end else if (b >= 8'hc2 && b < 8'hd0) begin
                  r                     = RSN_OK;
                  upd.in_sequence       = 1'b1;
                  upd.continuation_left = 2'd1;
               end else if (b >= 8'hd0 && b < 8'hf5) begin
                  r                     = RSN_OK;
                  upd.in_sequence       = 1'b1;
                  upd.continuation_left = b[5:4];
               end else begin
                  r = RSN_LEAD;
               end
            end else if (b[7:6] == 2'b10) begin
               r                     = RSN_OK;
               upd.continuation_left = base.continuation_left - 2'd1;
               if (upd.continuation_left == 2'd0) begin
                  upd.in_sequence = 1'b0;
               end
            end else begin
               r = RSN_CONT;
            end
         end else begin
            r = (b < 8'h20 || b[7]) ? RSN_CHAR : RSN_OK;
         end
         upd.error_latched = r;
      end

      if (item.empty_string) begin
         nxt        = STATE_CLEAR;
         res.produce = 1'b1;
         res.reason  = supported ? RSN_OK : RSN_CLASS;
      end else if (item.last_byte) begin
         nxt         = STATE_CLEAR;
         res.produce = 1'b1;
         res.reason  = (upd.error_latched == RSN_OK && upd.in_sequence) ?
                       RSN_TRUNC : upd.error_latched;
      end else begin
         nxt         = upd;
         res.produce = 1'b0;
         res.reason  = RSN_OK;
      end
   end

endmodule

// ===== sv/asn1_string_charset_check_core.sv =====
// Top level of the ASN.1 string character-set checker: input register, running
// state and result register around asn1cc_check. Uses asn1cc_pkg and the macros header.
//
// The block takes one content byte of an ASN.1 string per word and, on a
// token's last byte or on a zero-length token, gives one result word holding a
// valid flag and a reason code; bytes that end no token give no result. It
// takes one byte per clock cycle for as long as the result side does not
// stall; an accepted byte is held in the input register, then the type check
// and UTF-8 state update run in a single combinational stage into the result
// register. The running UTF-8 state and the first error of the token are held
// between bytes, so a token may be any length. A stall on the result side
// stalls the input side in the same cycle only when a byte that yields a
// result is waiting behind a full result register.
module asn1_string_charset_check_core
   import asn1cc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic [4:0] req_string_tag,
   input  logic       req_is_universal,
   input  logic       req_first_byte,
   input  logic       req_last_byte,
   input  logic       req_empty_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_string_valid,
   output logic [2:0] rsp_fail_reason
);

`include "asn1_string_charset_check_core_macros.svh"

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff, s1_item_in;
   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsn_type    reason_ff, reason_in;
   state_type  state_nxt;
   result_type res;
   logic       req_fire;
   logic       s1_fire;
   logic       out_free;

   asn1cc_check u_check (
      .item (s1_item_ff),
      .cur  (state_ff),
      .nxt  (state_nxt),
      .res  (res)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      s1_fire   = s1_valid_ff && (out_free || !res.produce);
      req_stall = s1_valid_ff && !s1_fire;
      req_fire  = req_valid && !req_stall;

      s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s1_item_in  = req_fire ? '{req_data_byte, req_string_tag, req_is_universal,
                                 req_first_byte, req_last_byte, req_empty_string}
                             : s1_item_ff;
      state_in    = s1_fire ? state_nxt : state_ff;

      if (s1_fire && res.produce) begin
         rsp_valid_in = 1'b1;
         reason_in    = res.reason;
      end else begin
         rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
         reason_in    = reason_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         state_ff     <= STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      reason_ff  <= reason_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fail_reason  = reason_ff;
   assign rsp_string_valid = (reason_ff == RSN_OK);

   `ASN1CC_ASSERT_SAME(a_seq_owes_bytes, clock, reset, state_ff.in_sequence, state_ff.continuation_left != 2'd0, "UTF-8 sequence open with no continuation bytes owed")
   `ASN1CC_ASSERT_NEXT(a_state_cleared, clock, reset, s1_fire && (s1_item_ff.last_byte || s1_item_ff.empty_string), state_ff == STATE_CLEAR, "running state not cleared after a token ended")
   `ASN1CC_ASSERT_NEXT(a_state_holds, clock, reset, !s1_fire, $stable(state_ff), "running state changed with no byte consumed")
   `ASN1CC_ASSERT_NEXT(a_result_loaded, clock, reset, s1_fire && res.produce, rsp_valid_ff && reason_ff == $past(res.reason), "result word not loaded from the finished token")

endmodule

// ===== sim/asn1_string_charset_check_core_tb.sv =====
// Self-checking testbench for asn1_string_charset_check_core.
// Drives string tokens byte by byte, predicts each verdict in the bench itself
// and compares every result word in order. Depends on asn1cc_pkg and the RTL.
module asn1_string_charset_check_core_tb;
   import asn1cc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte    = 8'h00;
   logic [4:0] req_string_tag   = 5'd0;
   logic       req_is_universal = 1'b0;
   logic       req_first_byte   = 1'b0;
   logic       req_last_byte    = 1'b0;
   logic       req_empty_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   logic       rsp_string_valid;
   logic [2:0] rsp_fail_reason;

   asn1_string_charset_check_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_string_tag   (req_string_tag),
      .req_is_universal (req_is_universal),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .req_empty_string (req_empty_string),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_string_valid (rsp_string_valid),
      .rsp_fail_reason  (rsp_fail_reason)
   );

   always #4 clock = ~clock;

   // Predicted running state of the token being checked.
   logic       utf8_open   = 1'b0;
   logic [1:0] utf8_owed   = 2'd0;
   rsn_type    token_error = RSN_OK;

   rsn_type    verdicts_due[$];
   logic [7:0] token_body[$];
   int         words_sent    = 0;
   int         directed_sent = 0;
   int         verdicts_seen = 0;
   int         mismatches    = 0;
   int         cycle_count   = 0;
   int         reasons_seen[0:7];
   bit         quiet_phase   = 1'b0;
   bit         stalling      = 1'b0;
   int         hold_count    = 0;

   function automatic item_type make_item(input logic [7:0] b, input logic [4:0] tag,
                                          input logic univ, input logic is_first,
                                          input logic is_last, input logic is_empty);
      item_type w;
      w.data_byte    = b;
      w.string_tag   = tag;
      w.is_universal = univ;
      w.first_byte   = is_first;
      w.last_byte    = is_last;
      w.empty_string = is_empty;
      return w;
   endfunction

   function automatic logic kind_known(input logic univ, input logic [4:0] tag);
      return univ && (tag == TAG_UTF8 || tag == TAG_PRINTABLE || tag == TAG_T61 ||
                      tag == TAG_IA5 || tag == TAG_VISIBLE);
   endfunction

   function automatic void clear_token();
      utf8_open   = 1'b0;
      utf8_owed   = 2'd0;
      token_error = RSN_OK;
   endfunction

   // Advances the predicted state by one accepted word; returns 1 when a verdict is due.
   function automatic logic charset_step(input item_type w, output rsn_type verdict);
      rsn_type    r;
      logic [7:0] b;
      logic [3:0] lead_nibble;
      b = w.data_byte;
      verdict = RSN_OK;
      if (w.empty_string) begin
         clear_token();
         verdict = kind_known(w.is_universal, w.string_tag) ? RSN_OK : RSN_CLASS;
         return 1'b1;
      end
      if (w.first_byte) begin
         clear_token();
      end
      if (token_error == RSN_OK) begin
         if (!kind_known(w.is_universal, w.string_tag)) begin
            r = RSN_CLASS;
         end else if (w.string_tag == TAG_PRINTABLE) begin
            if (b == 8'h20) begin
               r = RSN_OK;
            end else if (b < 8'h27 || b > 8'h7a || b == 8'h2a || b == 8'h3b ||
                         b == 8'h3c || b == 8'h3e || b == 8'h40) begin
               r = RSN_CHAR;
            end else begin
               r = RSN_OK;
            end
         end else if (w.string_tag == TAG_UTF8) begin
            r = RSN_OK;
            if (!utf8_open) begin
               if (b < 8'h80) begin
                  r = RSN_OK;
               end else if (b >= 8'hc2 && b < 8'hd0) begin
                  utf8_owed = 2'd1;
                  utf8_open = 1'b1;
               end else if (b >= 8'hd0 && b < 8'hf5) begin
                  lead_nibble = b[7:4] - 4'd12;
                  utf8_owed   = lead_nibble[1:0];
                  utf8_open   = 1'b1;
               end else begin
                  r = RSN_LEAD;
               end
            end else if (b[7:6] == 2'b10) begin
               utf8_owed = utf8_owed - 2'd1;
               if (utf8_owed == 2'd0) begin
                  utf8_open = 1'b0;
               end
            end else begin
               r = RSN_CONT;
            end
         end else begin
            r = (b < 8'h20 || b > 8'h7f) ? RSN_CHAR : RSN_OK;
         end
         token_error = r;
      end
      if (!w.last_byte) begin
         return 1'b0;
      end
      verdict = token_error;
      if (verdict == RSN_OK && utf8_open) begin
         verdict = RSN_TRUNC;
      end
      clear_token();
      return 1'b1;
   endfunction

   task automatic send_word(input item_type w);
      rsn_type verdict;
      @(negedge clock);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_data_byte    <= w.data_byte;
      req_string_tag   <= w.string_tag;
      req_is_universal <= w.is_universal;
      req_first_byte   <= w.first_byte;
      req_last_byte    <= w.last_byte;
      req_empty_string <= w.empty_string;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (charset_step(w, verdict)) begin
         verdicts_due.push_back(verdict);
      end
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [4:0] pick_known_tag();
      logic [4:0] tag;
      case ($urandom_range(0, 4))
         0: tag = TAG_UTF8;
         1: tag = TAG_PRINTABLE;
         2: tag = TAG_T61;
         3: tag = TAG_IA5;
         default: tag = TAG_VISIBLE;
      endcase
      return tag;
   endfunction

   task automatic send_token(input logic [4:0] tag, input logic univ);
      int n;
      n = token_body.size();
      if (n == 0) begin
         send_word(make_item(8'($urandom_range(0, 255)), tag, univ,
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1));
      end else begin
         for (int i = 0; i < n; i++) begin
            send_word(make_item(token_body[i], tag, univ, i == 0, i == n - 1, 1'b0));
         end
      end
   endtask

   task automatic fill_body(input logic [4:0] tag, input int len);
      int         extra;
      logic [7:0] b;
      token_body.delete();
      while (token_body.size() < len) begin
         if (tag == TAG_UTF8) begin
            extra = $urandom_range(0, 3);
            case (extra)
               0: b = 8'($urandom_range(8'h00, 8'h7f));
               1: b = 8'($urandom_range(8'hc2, 8'hdf));
               2: b = 8'($urandom_range(8'he0, 8'hef));
               default: b = 8'($urandom_range(8'hf0, 8'hf4));
            endcase
            token_body.push_back(b);
            for (int k = 0; k < extra && token_body.size() < len; k++) begin
               token_body.push_back(8'($urandom_range(8'h80, 8'hbf)));
            end
         end else if (tag == TAG_PRINTABLE) begin
            b = 8'($urandom_range(8'h27, 8'h7a));
            if (b == 8'h2a || b == 8'h3b || b == 8'h3c || b == 8'h3e || b == 8'h40) begin
               b = 8'h20;
            end
            token_body.push_back(b);
         end else begin
            token_body.push_back(8'($urandom_range(8'h20, 8'h7f)));
         end
      end
      if (len > 0 && $urandom_range(0, 3) == 0) begin
         token_body[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
      end
   endtask

   task automatic random_token();
      logic [4:0] tag;
      logic       univ;
      if ($urandom_range(0, 7) != 0) begin
         tag  = pick_known_tag();
         univ = 1'b1;
      end else begin
         tag  = 5'($urandom_range(0, 30));
         univ = 1'($urandom_range(0, 1));
      end
      fill_body(tag, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
      send_token(tag, univ);
   endtask

   task automatic test_directed_cases();
      send_word(make_item(8'hff, TAG_UTF8, 1'b1, 1'b1, 1'b0, 1'b1));
      send_word(make_item(8'h00, 5'd5, 1'b0, 1'b0, 1'b1, 1'b1));
      send_word(make_item(8'h41, TAG_VISIBLE, 1'b0, 1'b0, 1'b0, 1'b1));
      token_body = '{8'h20, 8'h27, 8'h7a};
      send_token(TAG_PRINTABLE, 1'b1);
      token_body = '{8'h2a};
      send_token(TAG_PRINTABLE, 1'b1);
      token_body = '{8'h40};
      send_token(TAG_PRINTABLE, 1'b1);
      token_body = '{8'h1f};
      send_token(TAG_IA5, 1'b1);
      token_body = '{8'h20, 8'h7f};
      send_token(TAG_T61, 1'b1);
      token_body = '{8'h80};
      send_token(TAG_VISIBLE, 1'b1);
      token_body = '{8'h41, 8'hc2, 8'h80};
      send_token(TAG_UTF8, 1'b1);
      token_body = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};
      send_token(TAG_UTF8, 1'b1);
      token_body = '{8'hc1};
      send_token(TAG_UTF8, 1'b1);
      token_body = '{8'he0, 8'h80};
      send_token(TAG_UTF8, 1'b1);
      token_body = '{8'hc2, 8'h41, 8'hf5};
      send_token(TAG_UTF8, 1'b1);
      send_word(make_item(8'h41, TAG_IA5, 1'b0, 1'b1, 1'b1, 1'b0));
      directed_sent = words_sent;
   endtask

   task automatic test_random_tokens(input int word_goal);
      while (words_sent < word_goal) begin
         random_token();
      end
   endtask

   task automatic test_noise_words(input int word_goal);
      logic [4:0] tag;
      while (words_sent < word_goal) begin
         if ($urandom_range(0, 1) == 0) begin
            tag = pick_known_tag();
         end else begin
            tag = 5'($urandom_range(0, 30));
         end
         send_word(make_item(8'($urandom_range(0, 255)), tag, $urandom_range(0, 7) != 0,
                             $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                             $urandom_range(0, 11) == 0));
      end
   endtask

   task automatic test_back_to_back(input int word_goal);
      quiet_phase = 1'b1;
      while (words_sent < word_goal) begin
         random_token();
      end
   endtask

   always @(negedge clock) begin
      if (reset || quiet_phase) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_count == 0) begin
            if (stalling) begin
               stalling   = 1'b0;
               hold_count = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(1, 30);
            end else if ($urandom_range(0, 1) == 0) begin
               stalling   = 1'b1;
               hold_count = $urandom_range(1, 18);
            end else begin
               hold_count = $urandom_range(1, 30);
            end
         end
         hold_count--;
         rsp_stall <= stalling;
      end
   end

   always @(posedge clock) begin
      rsn_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         verdicts_seen++;
         reasons_seen[rsp_fail_reason]++;
         if (verdicts_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word, string_valid %0d fail_reason %0d",
                     $time, rsp_string_valid, rsp_fail_reason);
         end else begin
            due = verdicts_due.pop_front();
            if (rsp_string_valid !== (due == RSN_OK)) begin
               mismatches++;
               $display("%0t: string_valid expected %0d, actual %0d",
                        $time, due == RSN_OK, rsp_string_valid);
            end
            if (rsp_fail_reason !== due) begin
               mismatches++;
               $display("%0t: fail_reason expected %0d, actual %0d",
                        $time, due, rsp_fail_reason);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding", $time, verdicts_due.size());
         $display("** asn1_string_charset_check_core: FAILED **");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < 8; i++) begin
         reasons_seen[i] = 0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_tokens(words_sent + 650);
      pause_until_drained();
      test_noise_words(words_sent + 350);
      pause_until_drained();
      test_back_to_back(words_sent + 320);
      pause_until_drained();
      repeat (8) @(posedge clock);
      if (verdicts_due.size() != 0) begin
         mismatches++;
         $display("%0t: %0d results never arrived, oldest expected fail_reason %0d",
                  $time, verdicts_due.size(), verdicts_due[0]);
      end
      $display("Sent %0d words (%0d directed) and checked %0d result words.",
               words_sent, directed_sent, verdicts_seen);
      $display("Reasons seen ok/class/char/lead/cont/trunc: %0d/%0d/%0d/%0d/%0d/%0d",
               reasons_seen[0], reasons_seen[1], reasons_seen[2], reasons_seen[3],
               reasons_seen[4], reasons_seen[5]);
      if (mismatches == 0) begin
         $display("** asn1_string_charset_check_core: PASSED **");
      end else begin
         $display("** asn1_string_charset_check_core: FAILED **");
      end
      $finish;
   end

endmodule
